// ----- hw/rtl/nll_pkg.sv -----
// Shared types and constants for the nonlinear ladder lowpass.
package nll_pkg;

  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int DEF_STATE_WIDTH  = 24;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int NUM_STAGES = 4;
  localparam int STAGE_W    = $clog2(NUM_STAGES);

  // Tanh results are signed Q1.28.
  localparam int TANH_FRAC = 28;
  localparam int TANH_W    = 30;

  localparam logic [CFG_W-1:0] RST_TUNING_GAIN   = 16'd7971;
  localparam logic [CFG_W-1:0] RST_FEEDBACK_GAIN = 16'd0;
  localparam logic [CFG_W-1:0] RST_INPUT_GAIN    = 16'd256;
  localparam logic [CFG_W-1:0] RST_OUTPUT_GAIN   = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TUNING_GAIN   = 2'd0,
    REG_FEEDBACK_GAIN = 2'd1,
    REG_INPUT_GAIN    = 2'd2,
    REG_OUTPUT_GAIN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FB_MUL,
    OP_FB_SUB,
    OP_TANH_DRIVE,
    OP_TANH_STATE,
    OP_DIFF_MUL,
    OP_DELTA,
    OP_UPDATE,
    OP_HALVE,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   from_input;
  } dp_cmd_t;

  typedef struct packed {
    logic tanh_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/nll_tanh.sv -----
// Multicycle fixed-point tanh unit: cubic seed and six doubling steps.
module nll_tanh import nll_pkg::*; #(
  parameter int STATE_WIDTH = DEF_STATE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [STATE_WIDTH+2:0]   operand_i,
  input  logic        [CFG_W-1:0]         gain_i,
  output logic                            done_o,
  output logic signed [TANH_W-1:0]        result_o
);

  localparam int VW    = STATE_WIDTH + 3;
  localparam int PW    = VW + CFG_W + 1;
  localparam int TSH   = STATE_WIDTH + 6;
  localparam int ASH   = STATE_WIDTH + 4 - TANH_FRAC;
  localparam int RSH   = (ASH > 0) ? ASH : 0;
  localparam int LSH   = (ASH < 0) ? -ASH : 0;
  localparam int EW    = PW + 1 + LSH;
  localparam int HALVINGS = 6;
  localparam int A_W   = 25;
  localparam int SQ_W  = 22;
  localparam int CB_W  = 19;
  localparam int Q3_W  = 18;
  localparam int DEN_W = 33;
  localparam int REM_W = 34;
  localparam int Q_W   = 29;
  localparam int DIV3_SH = 18;
  localparam logic [16:0] DIV3_MUL = 17'd87382;
  localparam logic [PW-1:0]    THRESH = PW'(1) << TSH;
  localparam logic [EW-1:0]    HALF   = (EW'(1) << RSH) >> 1;
  localparam logic [TANH_W-1:0] ONE = TANH_W'(1) << TANH_FRAC;

  typedef enum logic [2:0] {
    T_IDLE, T_PREP, T_SQ, T_CUBE, T_DIV3, T_DSQ, T_DIV, T_DONE
  } tanh_state_e;

  tanh_state_e state_q, state_d;
  logic [2:0]  iter_q, iter_d;
  logic [4:0]  bit_q, bit_d;

  logic signed [PW-1:0] prod_q;
  logic                 neg_q;
  logic [A_W-1:0]       a_q;
  logic [SQ_W-1:0]      sq_q;
  logic [CB_W-1:0]      cube_q;
  logic [TANH_W-1:0]    t_q;
  logic [DEN_W-1:0]     den_q;
  logic [REM_W-1:0]     rem_q;
  logic [Q_W-1:0]       quo_q;

  logic [PW-1:0]        mag;
  logic [EW-1:0]        a_rnd;
  logic [EW-1:0]        a_scl;
  logic                 big;
  logic [2*A_W-1:0]     sq_full;
  logic [SQ_W+A_W-1:0]  cube_full;
  logic [CB_W+16:0]     d3_full;
  logic [Q3_W-1:0]      q3;
  logic [2*TANH_W-1:0]  tt_full;
  logic [REM_W-1:0]     r2;
  logic                 ge;
  logic [Q_W-1:0]       quo_next;

  always_comb begin
    mag       = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    big       = (mag >= THRESH);
    a_rnd     = (EW'(mag) + HALF) >> RSH;
    a_scl     = a_rnd << LSH;
    sq_full   = a_q * a_q;
    cube_full = sq_q * a_q;
    d3_full   = cube_q * DIV3_MUL;
    q3        = d3_full[DIV3_SH+Q3_W-1:DIV3_SH];
    tt_full   = t_q * t_q;
    r2        = rem_q << 1;
    ge        = (r2 >= REM_W'(den_q));
    quo_next  = {quo_q[Q_W-2:0], ge};
  end

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    bit_d   = bit_q;
    unique case (state_q)
      T_IDLE: begin
        if (start_i) begin
          state_d = T_PREP;
        end
      end
      T_PREP: state_d = big ? T_DONE : T_SQ;
      T_SQ:   state_d = T_CUBE;
      T_CUBE: state_d = T_DIV3;
      T_DIV3: begin
        state_d = T_DSQ;
        iter_d  = '0;
      end
      T_DSQ: begin
        state_d = T_DIV;
        bit_d   = '0;
      end
      T_DIV: begin
        bit_d = bit_q + 5'd1;
        if (bit_q == 5'(Q_W - 1)) begin
          if (iter_q == 3'(HALVINGS - 1)) begin
            state_d = T_DONE;
          end else begin
            iter_d  = iter_q + 3'd1;
            state_d = T_DSQ;
          end
        end
      end
      T_DONE: state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      iter_q  <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (start_i) begin
          prod_q <= operand_i * $signed({1'b0, gain_i});
        end
      end
      T_PREP: begin
        neg_q <= prod_q[PW-1];
        a_q   <= a_scl[A_W+HALVINGS-1:HALVINGS];
        if (big) begin
          t_q <= ONE;
        end
      end
      T_SQ:   sq_q   <= sq_full[TANH_FRAC+SQ_W-1:TANH_FRAC];
      T_CUBE: cube_q <= cube_full[TANH_FRAC+CB_W-1:TANH_FRAC];
      T_DIV3: t_q    <= TANH_W'(a_q) - TANH_W'(q3);
      T_DSQ: begin
        den_q <= DEN_W'(ONE) + DEN_W'(tt_full[2*TANH_W-1:TANH_FRAC]);
        rem_q <= REM_W'(t_q);
        quo_q <= '0;
      end
      T_DIV: begin
        rem_q <= ge ? (r2 - REM_W'(den_q)) : r2;
        quo_q <= quo_next;
        if (bit_q == 5'(Q_W - 1)) begin
          t_q <= TANH_W'(quo_next);
        end
      end
      default: ;
    endcase
  end

  assign done_o   = (state_q == T_DONE);
  assign result_o = neg_q ? -$signed(t_q) : $signed(t_q);

endmodule

// ----- hw/rtl/nll_datapath.sv -----
// Datapath: gain registers, ladder stages, feedback, rounding and output register.
module nll_datapath import nll_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int STATE_WIDTH  = DEF_STATE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  dp_cmd_t                        cmd_i,
  output dp_status_t                     status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clipped_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int STW   = STATE_WIDTH;
  localparam int VW    = STW + 3;
  localparam int FPW   = STW + CFG_W + 1;
  localparam int FBW   = FPW + 1;
  localparam int FB_SH = 14;
  localparam int GPW   = 2 * CFG_W;
  localparam int DFW   = TANH_W + 1;
  localparam int PRW   = DFW + GPW + 1;
  // The stage step carries tanh, tuning and output-gain fractions.
  localparam int RS    = TANH_FRAC + CFG_W + 8 - (STW - 4);
  localparam int DW    = PRW - RS + 1;
  localparam int SUMW  = DW + 1;
  localparam int XS    = (SW - 1) - (STW - 4);
  localparam int XR    = (XS > 0) ? XS : 0;
  localparam int XL    = (XS < 0) ? -XS : 0;
  localparam int XW    = SW + 1 + XL;
  localparam int YS    = (STW - 4) - (SW - 1);
  localparam int YR    = (YS > 0) ? YS : 0;
  localparam int YL    = (YS < 0) ? -YS : 0;
  localparam int YW    = STW + 1 + YL;

  localparam logic [XW-1:0]  HALF_X = (XW'(1) << XR) >> 1;
  localparam logic [YW-1:0]  HALF_Y = (YW'(1) << YR) >> 1;
  localparam logic [FBW-1:0] HALF_FB = FBW'(1) << (FB_SH - 1);
  localparam logic [PRW-1:0] HALF_D = PRW'(1) << (RS - 1);
  localparam logic signed [SUMW-1:0] ST_MAX = SUMW'((64'(1) << (STW - 1)) - 64'(1));
  localparam logic signed [SUMW-1:0] ST_MIN = -ST_MAX - SUMW'(1);
  localparam logic [YW-1:0]  Y_POS = YW'((64'(1) << (SW - 1)) - 64'(1));
  localparam logic [YW-1:0]  Y_NEG = YW'(64'(1) << (SW - 1));

  logic [CFG_W-1:0] tg_q, fg_q, ig_q, og_q;
  logic [GPW-1:0]   gp_q;

  logic signed [STW-1:0]    st_q [NUM_STAGES];
  logic signed [STW-1:0]    hd_q, fv_q, x_q;
  logic signed [FPW-1:0]    fbp_q;
  logic signed [VW-1:0]     u_q;
  logic signed [TANH_W-1:0] td_q, tz_q;
  logic                     dest_drive_q;
  logic signed [PRW-1:0]    prod_q;
  logic signed [DW-1:0]     delta_q;
  logic                     clip_q;
  logic                     out_valid_q;
  logic signed [SW-1:0]     sample_out_q;
  logic                     clipped_q;

  logic                     tanh_start, tanh_done;
  logic signed [VW-1:0]     tanh_operand;
  logic signed [TANH_W-1:0] tanh_result;

  logic [SW-1:0]            s_mag;
  logic [XW-1:0]            x_mag;
  logic signed [STW-1:0]    x_new;
  logic [FPW-1:0]           fbp_mag;
  logic [FBW-1:0]           fb_rnd;
  logic signed [VW-1:0]     fb_val, u_new;
  logic signed [DFW-1:0]    diff;
  logic signed [GPW:0]      gp_s;
  logic [PRW-1:0]           p_mag, p_rnd;
  logic signed [DW-1:0]     delta_new;
  logic signed [SUMW-1:0]   upd_sum, upd_sat;
  logic                     upd_clip;
  logic signed [STW:0]      hv_sum;
  logic [STW:0]             hv_mag;
  logic [STW:0]             hv_rnd;
  logic signed [STW-1:0]    fv_new;
  logic [STW-1:0]           fv_mag;
  logic [YW-1:0]            y_mag;
  logic signed [SW-1:0]     y_new;
  logic                     y_clip;

  always_comb begin
    s_mag   = sample_in_i[SW-1] ? SW'(-sample_in_i) : SW'(sample_in_i);
    x_mag   = ((XW'(s_mag) + HALF_X) >> XR) << XL;
    x_new   = sample_in_i[SW-1] ? -$signed(STW'(x_mag)) : $signed(STW'(x_mag));

    fbp_mag = fbp_q[FPW-1] ? FPW'(-fbp_q) : FPW'(fbp_q);
    fb_rnd  = (FBW'(fbp_mag) + HALF_FB) >> FB_SH;
    fb_val  = fbp_q[FPW-1] ? -$signed(VW'(fb_rnd)) : $signed(VW'(fb_rnd));
    u_new   = VW'(x_q) - fb_val;

    diff    = DFW'(td_q) - DFW'(tz_q);
    gp_s    = $signed({1'b0, gp_q});

    p_mag     = prod_q[PRW-1] ? PRW'(-prod_q) : PRW'(prod_q);
    p_rnd     = (p_mag + HALF_D) >> RS;
    delta_new = prod_q[PRW-1] ? -$signed(DW'(p_rnd)) : $signed(DW'(p_rnd));

    upd_sum  = SUMW'(st_q[0]) + SUMW'(delta_q);
    upd_clip = 1'b0;
    upd_sat  = upd_sum;
    if (upd_sum > ST_MAX) begin
      upd_sat  = ST_MAX;
      upd_clip = 1'b1;
    end else if (upd_sum < ST_MIN) begin
      upd_sat  = ST_MIN;
      upd_clip = 1'b1;
    end

    hv_sum = (STW+1)'(st_q[NUM_STAGES-1]) + (STW+1)'(hd_q);
    hv_mag = hv_sum[STW] ? (STW+1)'(-hv_sum) : (STW+1)'(hv_sum);
    hv_rnd = (hv_mag + (STW+1)'(1)) >> 1;
    fv_new = hv_sum[STW] ? -$signed(STW'(hv_rnd)) : $signed(STW'(hv_rnd));

    fv_mag = fv_q[STW-1] ? STW'(-fv_q) : STW'(fv_q);
    y_mag  = ((YW'(fv_mag) + HALF_Y) >> YR) << YL;
    y_clip = 1'b0;
    if (fv_q[STW-1]) begin
      if (y_mag > Y_NEG) begin
        y_new  = -$signed(SW'(Y_NEG));
        y_clip = 1'b1;
      end else begin
        y_new = -$signed(SW'(y_mag));
      end
    end else begin
      if (y_mag > Y_POS) begin
        y_new  = $signed(SW'(Y_POS));
        y_clip = 1'b1;
      end else begin
        y_new = $signed(SW'(y_mag));
      end
    end
  end

  assign tanh_start   = (cmd_i.op == OP_TANH_DRIVE) || (cmd_i.op == OP_TANH_STATE);
  assign tanh_operand = (cmd_i.op == OP_TANH_STATE) ? VW'(st_q[0]) :
                        cmd_i.from_input ? u_q : VW'(st_q[NUM_STAGES-1]);

  nll_tanh #(
    .STATE_WIDTH(STATE_WIDTH)
  ) u_tanh (
    .clk_i,
    .rst_ni,
    .start_i   (tanh_start),
    .operand_i (tanh_operand),
    .gain_i    (ig_q),
    .done_o    (tanh_done),
    .result_o  (tanh_result)
  );

  // Gain registers; the product of tuning and output gain is kept ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tg_q <= RST_TUNING_GAIN;
      fg_q <= RST_FEEDBACK_GAIN;
      ig_q <= RST_INPUT_GAIN;
      og_q <= RST_OUTPUT_GAIN;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TUNING_GAIN:   tg_q <= cfg_data_i;
        REG_FEEDBACK_GAIN: fg_q <= cfg_data_i;
        REG_INPUT_GAIN:    ig_q <= cfg_data_i;
        REG_OUTPUT_GAIN:   og_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    gp_q <= tg_q * og_q;
  end

  // Filter state. The stages rotate on every update so that the stage being
  // worked on always sits in slot zero and the one just updated in the last slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        st_q[i] <= '0;
      end
      hd_q        <= '0;
      fv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_UPDATE) begin
        for (int i = 0; i < NUM_STAGES - 1; i++) begin
          st_q[i] <= st_q[i+1];
        end
        st_q[NUM_STAGES-1] <= STW'(upd_sat);
      end
      if (cmd_i.op == OP_HALVE) begin
        fv_q <= fv_new;
        hd_q <= st_q[NUM_STAGES-1];
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tanh_done) begin
      if (dest_drive_q) begin
        td_q <= tanh_result;
      end else begin
        tz_q <= tanh_result;
      end
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q    <= x_new;
        clip_q <= 1'b0;
      end
      OP_FB_MUL:     fbp_q        <= $signed({1'b0, fg_q}) * fv_q;
      OP_FB_SUB:     u_q          <= u_new;
      OP_TANH_DRIVE: dest_drive_q <= 1'b1;
      OP_TANH_STATE: dest_drive_q <= 1'b0;
      OP_DIFF_MUL:   prod_q       <= diff * gp_s;
      OP_DELTA:      delta_q      <= delta_new;
      OP_UPDATE:     clip_q       <= clip_q | upd_clip;
      OP_OUT: begin
        sample_out_q <= y_new;
        clipped_q    <= clip_q | y_clip;
      end
      default: ;
    endcase
  end

  assign status_o.tanh_done = tanh_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign sample_out_o       = sample_out_q;
  assign clipped_o          = clipped_q;

endmodule

// ----- hw/rtl/nll_ctrl.sv -----
// Controller: sequences the two passes and four stage updates of each sample.
module nll_ctrl import nll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

  typedef enum logic [3:0] {
    C_IDLE, C_FB_MUL, C_FB_SUB, C_TD_START, C_TD_WAIT, C_TZ_START,
    C_TZ_WAIT, C_MUL, C_RND, C_UPD, C_HALVE, C_OUT
  } ctrl_state_e;

  ctrl_state_e        state_q, state_d;
  logic               pass_q, pass_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic               stall_q, stall_d;

  always_comb begin
    state_d          = state_q;
    pass_d           = pass_q;
    stage_d          = stage_q;
    stall_d          = stall_q;
    cmd_o.op         = OP_NONE;
    cmd_o.from_input = (stage_q == '0);
    unique case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          pass_d   = 1'b0;
          stall_d  = 1'b1;
          state_d  = C_FB_MUL;
        end
      end
      C_FB_MUL: begin
        cmd_o.op = OP_FB_MUL;
        state_d  = C_FB_SUB;
      end
      C_FB_SUB: begin
        cmd_o.op = OP_FB_SUB;
        stage_d  = '0;
        state_d  = C_TD_START;
      end
      C_TD_START: begin
        cmd_o.op = OP_TANH_DRIVE;
        state_d  = C_TD_WAIT;
      end
      C_TD_WAIT: begin
        if (status_i.tanh_done) begin
          state_d = C_TZ_START;
        end
      end
      C_TZ_START: begin
        cmd_o.op = OP_TANH_STATE;
        state_d  = C_TZ_WAIT;
      end
      C_TZ_WAIT: begin
        if (status_i.tanh_done) begin
          state_d = C_MUL;
        end
      end
      C_MUL: begin
        cmd_o.op = OP_DIFF_MUL;
        state_d  = C_RND;
      end
      C_RND: begin
        cmd_o.op = OP_DELTA;
        state_d  = C_UPD;
      end
      C_UPD: begin
        cmd_o.op = OP_UPDATE;
        if (stage_q == LAST_STAGE) begin
          state_d = C_HALVE;
        end else begin
          stage_d = stage_q + STAGE_W'(1);
          state_d = C_TD_START;
        end
      end
      C_HALVE: begin
        cmd_o.op = OP_HALVE;
        if (pass_q) begin
          state_d = C_OUT;
        end else begin
          pass_d  = 1'b1;
          state_d = C_FB_MUL;
        end
      end
      C_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          stall_d  = 1'b0;
          state_d  = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      pass_q  <= 1'b0;
      stage_q <= '0;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      stage_q <= stage_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ----- hw/rtl/nonlinear_ladder_lowpass.sv -----
// Four-stage tanh-saturated ladder lowpass, twice oversampled, fixed point.
// Each accepted sample runs two passes of feedback subtraction and four stage
// updates through one shared tanh unit, then one filtered sample comes out with
// a flag that is set when the output or any stage saturated. The tanh unit sets
// the time from acceptance to result, as it evaluates sixteen tanh values per
// sample and each one runs six restoring divisions of 29 quotient bits (an
// argument of magnitude four or more skips the divisions). The input stalls
// while a sample is in work; a finished result waits in the output register
// while the next sample is taken. Gain registers take writes at any time on the
// configuration port and should change only while the filter is idle.
module nonlinear_ladder_lowpass import nll_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int STATE_WIDTH  = DEF_STATE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           clipped_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  nll_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  nll_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .sample_in_i,
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o,
    .out_stall_i,
    .sample_out_o,
    .clipped_o
  );

endmodule
